### design/sliding_window_median_defines.svh
// Assertion helpers for the sliding window median filter.
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// Checked on every rising edge outside reset.
`define SWM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SWM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### design/swm_pkg.sv
package swm_pkg;

   localparam int MAX_WINDOW_DEF = 64;
   localparam int CFG_W          = 7;
   localparam int SAMPLE_W       = 32;
   localparam int MEDIAN_W       = 33;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd3;

   // word index of the registers
   localparam logic REG_WINDOW_SIZE = 1'b0;

   typedef struct packed {
      logic step;
      logic drain;
   } cell_ctl_type;

endpackage

### design/sliding_window_median.sv
// Sliding window median filter.
// Requests (req_sample, req_restart) arrive on a valid/ready channel; each one
// that completes the window yields one response rsp_median_x2, the sum of the
// two middle values of the sorted window (median with one fractional bit).
// Requests while the window is still filling give no response. req_restart
// empties the window before its sample is taken. window_size (1..MAX_WINDOW,
// 0 acts as 1, larger acts as MAX_WINDOW) is written through the csr_ APB port
// at byte address 0. The user must write it only while the block is idle;
// the block does not enforce this. Samples sit sorted in a row of MAX_WINDOW
// cells that shift one place per update, so one request is taken per cycle
// unless stalled; a response passes the median stage and the output register.
// After window_size shrinks, the next request first waits while the row drops
// its oldest entries to the new size. A stalled response stays in the output
// register; one more finished result waits in the median stage, and only then
// req_ready falls. Synchronous reset empties the window, sets window_size to
// 3 and drops any pending response; cell contents are not cleared.
`include "sliding_window_median_defines.svh"

module sliding_window_median #(
   parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [swm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [swm_pkg::MEDIAN_W-1:0] rsp_median_x2,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [swm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [swm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [swm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import swm_pkg::*;

   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int FW = $clog2(MAX_WINDOW + 1);
   localparam int CW = (FW > CFG_W) ? FW : CFG_W;

   logic [CFG_W-1:0] window_size_ff, window_size_in;
   logic [FW-1:0]    fill_count_ff, fill_count_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    lo_idx_ff, lo_idx_in, hi_idx_ff, hi_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [MEDIAN_W-1:0] median_ff, median_in;

   logic [CW-1:0] ws_ext;
   logic [FW-1:0] w_eff, fill_use, kept;
   logic          drain_need, advance, do_step, do_drain, del_any, result;
   logic [AW-1:0] target_age;
   cell_ctl_type  ctl;

   logic signed [SAMPLE_W-1:0] cell_value [MAX_WINDOW];
   logic [AW-1:0]              cell_age   [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]      cell_gt, post_gt, del_vec, above, occ, post_occ;
   logic signed [SAMPLE_W-1:0] post_value [MAX_WINDOW];
   logic [AW-1:0]              post_age   [MAX_WINDOW];

   // ---- configuration port
   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_WINDOW_SIZE) ?
                       CSR_DATA_W'(window_size_ff) : '0;

   always_comb begin
      window_size_in = window_size_ff;
      if (csr_wr && csr_paddr[2] == REG_WINDOW_SIZE) begin
         window_size_in = csr_pwdata[CFG_W-1:0];
      end
   end

   // ---- control
   assign ws_ext = CW'(window_size_ff);
   always_comb begin
      if (ws_ext == '0) begin
         w_eff = FW'(1);
      end else if (ws_ext > CW'(MAX_WINDOW)) begin
         w_eff = FW'(MAX_WINDOW);
      end else begin
         w_eff = ws_ext[FW-1:0];
      end
   end

   assign fill_use   = req_restart ? '0 : fill_count_ff;
   assign drain_need = !req_restart && (fill_count_ff > w_eff);
   assign advance    = !pend_ff || !rsp_valid_ff || rsp_ready;
   assign req_ready  = advance && !drain_need;
   assign do_step    = req_valid && req_ready;
   assign do_drain   = req_valid && drain_need && advance;
   assign ctl.step   = do_step;
   assign ctl.drain  = do_drain;

   assign del_any    = do_drain || (do_step && fill_use == w_eff);
   assign kept       = fill_use - FW'(del_any);
   assign target_age = do_drain ? AW'(fill_use - FW'(1)) : AW'(w_eff - FW'(1));
   assign result     = do_step && (kept + FW'(1) == w_eff);

   always_comb begin
      fill_count_in = fill_count_ff;
      if (do_drain) begin
         fill_count_in = fill_use - FW'(1);
      end else if (do_step) begin
         fill_count_in = kept + FW'(1);
      end
   end

   // ---- cell row
   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      localparam logic [FW-1:0] IDX = FW'(i);
      logic signed [SAMPLE_W-1:0] up_v, dn_v;
      logic [AW-1:0]              up_a, dn_a;
      logic                       up_g, dn_g;

      assign occ[i]      = fill_use > IDX;
      assign post_occ[i] = kept > IDX;
      assign above[i]    = |del_vec[i:0];

      if (i == MAX_WINDOW - 1) begin : g_top
         assign up_v = '0;
         assign up_a = '0;
         assign up_g = 1'b0;
      end else begin : g_mid
         assign up_v = cell_value[i+1];
         assign up_a = cell_age[i+1];
         assign up_g = cell_gt[i+1];
      end

      if (i == 0) begin : g_bot
         assign dn_v = '0;
         assign dn_a = '0;
         assign dn_g = 1'b0;
      end else begin : g_low
         assign dn_v = post_value[i-1];
         assign dn_a = post_age[i-1];
         assign dn_g = post_gt[i-1];
      end

      swm_cell #(.AGE_W(AW)) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .sample     (req_sample),
         .target_age (target_age),
         .del_en     (del_any),
         .occ        (occ[i]),
         .post_occ   (post_occ[i]),
         .above      (above[i]),
         .up_value   (up_v),
         .up_age     (up_a),
         .up_gt      (up_g),
         .dn_value   (dn_v),
         .dn_age     (dn_a),
         .dn_gt      (dn_g),
         .value      (cell_value[i]),
         .age        (cell_age[i]),
         .gt         (cell_gt[i]),
         .post_value (post_value[i]),
         .post_age   (post_age[i]),
         .post_gt    (post_gt[i]),
         .del        (del_vec[i])
      );
   end

   // ---- median stage and output register
   always_comb begin
      pend_in   = pend_ff;
      lo_idx_in = lo_idx_ff;
      hi_idx_in = hi_idx_ff;
      if (advance) begin
         pend_in   = result;
         lo_idx_in = AW'((w_eff - FW'(1)) >> 1);
         hi_idx_in = AW'(w_eff >> 1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      median_in    = median_ff;
      if (pend_ff && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in = 1'b1;
         median_in    = MEDIAN_W'(cell_value[lo_idx_ff]) + MEDIAN_W'(cell_value[hi_idx_ff]);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_median_x2 = median_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
         fill_count_ff  <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         window_size_ff <= window_size_in;
         fill_count_ff  <= fill_count_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_idx_ff <= lo_idx_in;
      hi_idx_ff <= hi_idx_in;
      median_ff <= median_in;
   end

   // ---- checks
   `SWM_ASSERT_ALWAYS(a_fill_bound, reset || fill_count_ff <= FW'(MAX_WINDOW), "fill count above depth")
   `SWM_ASSERT(a_single_drop, do_step |-> $onehot0(del_vec), "more than one entry dropped")
   `SWM_ASSERT(a_drain_fill, do_drain |=> fill_count_ff == $past(fill_count_ff) - FW'(1), "drain did not shrink fill")
   `SWM_ASSERT(a_pend_hold, (pend_ff && !advance) |=> pend_ff, "pending median lost")

endmodule

### design/swm_cell.sv
module swm_cell #(
   parameter int AGE_W = 6
) (
   input  logic                              clock,
   input  swm_pkg::cell_ctl_type             ctl,
   input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
   input  logic [AGE_W-1:0]                  target_age,
   input  logic                              del_en,
   input  logic                              occ,
   input  logic                              post_occ,
   input  logic                              above,
   input  logic signed [swm_pkg::SAMPLE_W-1:0] up_value,
   input  logic [AGE_W-1:0]                  up_age,
   input  logic                              up_gt,
   input  logic signed [swm_pkg::SAMPLE_W-1:0] dn_value,
   input  logic [AGE_W-1:0]                  dn_age,
   input  logic                              dn_gt,
   output logic signed [swm_pkg::SAMPLE_W-1:0] value,
   output logic [AGE_W-1:0]                  age,
   output logic                              gt,
   output logic signed [swm_pkg::SAMPLE_W-1:0] post_value,
   output logic [AGE_W-1:0]                  post_age,
   output logic                              post_gt,
   output logic                              del
);
   import swm_pkg::*;

   logic signed [SAMPLE_W-1:0] value_ff, value_in;
   logic [AGE_W-1:0]           age_ff, age_in;

   assign value = value_ff;
   assign age   = age_ff;
   assign gt    = value_ff > sample;
   assign del   = del_en && occ && (age_ff == target_age);

   // view after the leaving entry is squeezed out
   assign post_value = above ? up_value : value_ff;
   assign post_age   = above ? up_age : age_ff;
   assign post_gt    = post_occ && (above ? up_gt : gt);

   always_comb begin
      value_in = value_ff;
      age_in   = age_ff;
      if (ctl.drain) begin
         value_in = post_value;
         age_in   = post_age;
      end else if (ctl.step) begin
         if (dn_gt) begin
            value_in = dn_value;
            age_in   = dn_age + AGE_W'(1);
         end else if (post_gt || !post_occ) begin
            value_in = sample;
            age_in   = '0;
         end else begin
            value_in = post_value;
            age_in   = post_age + AGE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      age_ff   <= age_in;
   end

endmodule
